/* hdl/ycc2bgr_pkg.sv */
package ycc2bgr_pkg;

	localparam int unsigned BYTE_W  = 8;
	localparam int unsigned CHR_W   = 9;   // centered chroma, signed
	localparam int unsigned COEF_W  = 18;  // unsigned Q16 coefficient
	localparam int unsigned LUMA_W  = 26;  // scaled luma, signed Q16
	localparam int unsigned ACC_W   = 28;  // products and sums, signed Q16
	localparam int unsigned FRAC_W  = 16;
	localparam int unsigned IDX_W   = 2;
	localparam int unsigned CFG_W   = 2;

	localparam logic [16:0] LUMA_GAIN = 17'd76309;  // 65536 * 255/219
	localparam logic [BYTE_W-1:0] LUMA_OFS = 8'd16;
	localparam logic [BYTE_W-1:0] CHR_MID  = 8'd128;
	localparam logic [ACC_W-1:0] HALF_LSB = ACC_W'(32768);

	typedef enum logic [1:0] {
		FMT_NV12  = 2'd0,
		FMT_NV21  = 2'd1,
		FMT_RGB24 = 2'd2,
		FMT_BGR24 = 2'd3
	} fmt_t;

	localparam logic [IDX_W-1:0] REG_IN_FMT             = 2'd0;
	localparam logic [IDX_W-1:0] REG_COLOR_MATRIX       = 2'd1;
	localparam logic [IDX_W-1:0] REG_QUANTIZATION_RANGE = 2'd2;

	typedef struct packed {
		fmt_t in_fmt;
		logic color_matrix;
		logic quantization_range;
	} cfg_t;

	typedef struct packed {
		logic [BYTE_W-1:0] sample_first;
		logic [BYTE_W-1:0] sample_second;
		logic [BYTE_W-1:0] sample_third;
	} pix_t;

	typedef struct packed {
		logic [BYTE_W-1:0] blue;
		logic [BYTE_W-1:0] green;
		logic [BYTE_W-1:0] red;
	} bgr_t;

	typedef struct packed {
		logic [COEF_W-1:0] kb;
		logic [COEF_W-1:0] kgu;
		logic [COEF_W-1:0] kgv;
		logic [COEF_W-1:0] kr;
	} coef_t;

	// after front stage: centered chroma, scaled luma, chosen coefficients
	typedef struct packed {
		logic                     bypass;
		bgr_t                     raw;
		logic signed [LUMA_W-1:0] lum;
		logic signed [CHR_W-1:0]  cu;
		logic signed [CHR_W-1:0]  cv;
		coef_t                    coef;
	} front_t;

	typedef struct packed {
		logic                     bypass;
		bgr_t                     raw;
		logic signed [LUMA_W-1:0] lum;
		logic signed [ACC_W-1:0]  pb;
		logic signed [ACC_W-1:0]  pgu;
		logic signed [ACC_W-1:0]  pgv;
		logic signed [ACC_W-1:0]  pr;
	} prod_t;

	typedef struct packed {
		logic                    bypass;
		bgr_t                    raw;
		logic signed [ACC_W-1:0] sb;
		logic signed [ACC_W-1:0] sg;
		logic signed [ACC_W-1:0] sr;
	} sum_t;

	// Q16 chroma coefficients; limited range folds in the 255/224 gain
	function automatic coef_t coef_lookup(input logic matrix, input logic limited);
		coef_t c;
		unique case ({matrix, limited})
			2'b00: c = '{kb: 18'd116130, kgu: 18'd22553, kgv: 18'd46802, kr: 18'd91881};
			2'b01: c = '{kb: 18'd132201, kgu: 18'd25675, kgv: 18'd53279, kr: 18'd104597};
			2'b10: c = '{kb: 18'd121609, kgu: 18'd12276, kgv: 18'd30679, kr: 18'd103206};
			2'b11: c = '{kb: 18'd138438, kgu: 18'd13975, kgv: 18'd34925, kr: 18'd117489};
			default: c = '0;
		endcase
		return c;
	endfunction

endpackage

/* hdl/ycc2bgr_if.sv */
interface ycc2bgr_in_if;
	logic                          valid;
	logic                          ready;
	logic [ycc2bgr_pkg::BYTE_W-1:0] sample_first;
	logic [ycc2bgr_pkg::BYTE_W-1:0] sample_second;
	logic [ycc2bgr_pkg::BYTE_W-1:0] sample_third;

	modport source(output valid, sample_first, sample_second, sample_third, input ready);
	modport sink(input valid, sample_first, sample_second, sample_third, output ready);
endinterface

interface ycc2bgr_out_if;
	logic                          valid;
	logic                          ready;
	logic [ycc2bgr_pkg::BYTE_W-1:0] blue;
	logic [ycc2bgr_pkg::BYTE_W-1:0] green;
	logic [ycc2bgr_pkg::BYTE_W-1:0] red;

	modport source(output valid, blue, green, red, input ready);
	modport sink(input valid, blue, green, red, output ready);
endinterface

/* hdl/ycc2bgr_front.sv */
module ycc2bgr_front (
	input  logic                 clk,
	input  logic                 arst_n,
	input  ycc2bgr_pkg::cfg_t    cfg,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  ycc2bgr_pkg::pix_t    pix,
	output logic                 out_valid,
	input  logic                 out_ready,
	output ycc2bgr_pkg::front_t  out_data
);

	logic                 valid_s1;
	ycc2bgr_pkg::front_t  data_s1;
	ycc2bgr_pkg::front_t  nxt;
	logic [ycc2bgr_pkg::BYTE_W-1:0] ub;
	logic [ycc2bgr_pkg::BYTE_W-1:0] vb;
	logic signed [ycc2bgr_pkg::CHR_W-1:0] y_ofs;

	assign in_ready = !valid_s1 || out_ready;

	always_comb begin
		nxt = '0;
		ub  = pix.sample_second;
		vb  = pix.sample_third;
		unique case (cfg.in_fmt)
			ycc2bgr_pkg::FMT_NV12: begin
				nxt.bypass = 1'b0;
			end
			ycc2bgr_pkg::FMT_NV21: begin
				nxt.bypass = 1'b0;
				ub = pix.sample_third;
				vb = pix.sample_second;
			end
			ycc2bgr_pkg::FMT_RGB24: begin
				nxt.bypass = 1'b1;
				nxt.raw = '{blue: pix.sample_third, green: pix.sample_second,
					red: pix.sample_first};
			end
			ycc2bgr_pkg::FMT_BGR24: begin
				nxt.bypass = 1'b1;
				nxt.raw = '{blue: pix.sample_first, green: pix.sample_second,
					red: pix.sample_third};
			end
			default: nxt.bypass = 1'b1;
		endcase
		nxt.cu = $signed({1'b0, ub}) - $signed({1'b0, ycc2bgr_pkg::CHR_MID});
		nxt.cv = $signed({1'b0, vb}) - $signed({1'b0, ycc2bgr_pkg::CHR_MID});
		y_ofs  = $signed({1'b0, pix.sample_first}) - $signed({1'b0, ycc2bgr_pkg::LUMA_OFS});
		if (cfg.quantization_range) begin
			nxt.lum = ycc2bgr_pkg::LUMA_W'(y_ofs * $signed({1'b0, ycc2bgr_pkg::LUMA_GAIN}));
		end else begin
			nxt.lum = $signed(ycc2bgr_pkg::LUMA_W'({pix.sample_first,
				ycc2bgr_pkg::FRAC_W'(0)}));
		end
		nxt.coef = ycc2bgr_pkg::coef_lookup(cfg.color_matrix, cfg.quantization_range);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			data_s1 <= nxt;
		end
	end

	assign out_valid = valid_s1;
	assign out_data  = data_s1;

endmodule

/* hdl/ycc2bgr_mult.sv */
module ycc2bgr_mult (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  ycc2bgr_pkg::front_t  in_data,
	output logic                 out_valid,
	input  logic                 out_ready,
	output ycc2bgr_pkg::prod_t   out_data
);

	logic               valid_s2;
	ycc2bgr_pkg::prod_t data_s2;
	ycc2bgr_pkg::prod_t nxt;

	function automatic logic signed [ycc2bgr_pkg::ACC_W-1:0] scale(
		input logic [ycc2bgr_pkg::COEF_W-1:0] k,
		input logic signed [ycc2bgr_pkg::CHR_W-1:0] c
	);
		logic signed [ycc2bgr_pkg::ACC_W-1:0] ks;
		logic signed [ycc2bgr_pkg::ACC_W-1:0] cs;
		ks = $signed(ycc2bgr_pkg::ACC_W'(k));
		cs = ycc2bgr_pkg::ACC_W'(c);
		return ks * cs;
	endfunction

	assign in_ready = !valid_s2 || out_ready;

	always_comb begin
		nxt.bypass = in_data.bypass;
		nxt.raw    = in_data.raw;
		nxt.lum    = in_data.lum;
		nxt.pb     = scale(in_data.coef.kb, in_data.cu);
		nxt.pgu    = scale(in_data.coef.kgu, in_data.cu);
		nxt.pgv    = scale(in_data.coef.kgv, in_data.cv);
		nxt.pr     = scale(in_data.coef.kr, in_data.cv);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (in_ready) begin
			valid_s2 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			data_s2 <= nxt;
		end
	end

	assign out_valid = valid_s2;
	assign out_data  = data_s2;

endmodule

/* hdl/ycc2bgr_sum.sv */
module ycc2bgr_sum (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  ycc2bgr_pkg::prod_t  in_data,
	output logic                out_valid,
	input  logic                out_ready,
	output ycc2bgr_pkg::sum_t   out_data
);

	logic                                 valid_s3;
	ycc2bgr_pkg::sum_t                    data_s3;
	ycc2bgr_pkg::sum_t                    nxt;
	logic signed [ycc2bgr_pkg::ACC_W-1:0] lum_x;

	assign in_ready = !valid_s3 || out_ready;

	always_comb begin
		lum_x      = ycc2bgr_pkg::ACC_W'(in_data.lum);
		nxt.bypass = in_data.bypass;
		nxt.raw    = in_data.raw;
		nxt.sb     = lum_x + in_data.pb;
		nxt.sg     = lum_x - in_data.pgu - in_data.pgv;
		nxt.sr     = lum_x + in_data.pr;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (in_ready) begin
			valid_s3 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			data_s3 <= nxt;
		end
	end

	assign out_valid = valid_s3;
	assign out_data  = data_s3;

endmodule

/* hdl/ycc2bgr_clamp.sv */
module ycc2bgr_clamp (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  ycc2bgr_pkg::sum_t  in_data,
	output logic               out_valid,
	input  logic               out_ready,
	output ycc2bgr_pkg::bgr_t  out_data
);

	logic              valid_s4;
	ycc2bgr_pkg::bgr_t data_s4;
	ycc2bgr_pkg::bgr_t nxt;

	// round half up, then clamp to a byte
	function automatic logic [ycc2bgr_pkg::BYTE_W-1:0] to_byte(
		input logic signed [ycc2bgr_pkg::ACC_W-1:0] acc
	);
		logic [ycc2bgr_pkg::ACC_W-1:0] v;
		logic [ycc2bgr_pkg::BYTE_W-1:0] b;
		v = acc + ycc2bgr_pkg::HALF_LSB;
		if (v[ycc2bgr_pkg::ACC_W-1]) begin
			b = '0;
		end else if (|v[ycc2bgr_pkg::ACC_W-2:ycc2bgr_pkg::FRAC_W+ycc2bgr_pkg::BYTE_W]) begin
			b = '1;
		end else begin
			b = v[ycc2bgr_pkg::FRAC_W+ycc2bgr_pkg::BYTE_W-1:ycc2bgr_pkg::FRAC_W];
		end
		return b;
	endfunction

	assign in_ready = !valid_s4 || out_ready;

	always_comb begin
		if (in_data.bypass) begin
			nxt = in_data.raw;
		end else begin
			nxt.blue  = to_byte(in_data.sb);
			nxt.green = to_byte(in_data.sg);
			nxt.red   = to_byte(in_data.sr);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4 <= 1'b0;
		end else if (in_ready) begin
			valid_s4 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			data_s4 <= nxt;
		end
	end

	assign out_valid = valid_s4;
	assign out_data  = data_s4;

endmodule

/* hdl/ycbcr_to_bgr_pixel_converter.sv */
// An accepted input request reaches the output through four register stages
// (format select and luma scale, chroma multiplies, matrix sums, round and
// clamp), each moving on its own; one pixel per cycle unless the output stalls.
// A stall at the output backs up stage by stage; bubbles are squeezed out.
// Reset (arst_n low) clears all stage valid bits and the format, matrix and
// range registers to NV12, BT.601, full range.
module ycbcr_to_bgr_pixel_converter (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [ycc2bgr_pkg::IDX_W-1:0]    cfg_index,
	input  logic [ycc2bgr_pkg::CFG_W-1:0]    cfg_data,
	ycc2bgr_in_if.sink                       pix_in,
	ycc2bgr_out_if.source                    pix_out
);

	ycc2bgr_pkg::cfg_t   cfg_q;
	ycc2bgr_pkg::pix_t   pix;
	ycc2bgr_pkg::front_t front_d;
	ycc2bgr_pkg::prod_t  prod_d;
	ycc2bgr_pkg::sum_t   sum_d;
	ycc2bgr_pkg::bgr_t   bgr_d;
	logic v1, r1, v2, r2, v3, r3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '{in_fmt: ycc2bgr_pkg::FMT_NV12, color_matrix: 1'b0,
				quantization_range: 1'b0};
		end else if (cfg_we) begin
			unique case (cfg_index)
				ycc2bgr_pkg::REG_IN_FMT:
					cfg_q.in_fmt <= ycc2bgr_pkg::fmt_t'(cfg_data[1:0]);
				ycc2bgr_pkg::REG_COLOR_MATRIX:
					cfg_q.color_matrix <= cfg_data[0];
				ycc2bgr_pkg::REG_QUANTIZATION_RANGE:
					cfg_q.quantization_range <= cfg_data[0];
				default: ;
			endcase
		end
	end

	assign pix = '{sample_first: pix_in.sample_first, sample_second: pix_in.sample_second,
		sample_third: pix_in.sample_third};

	ycc2bgr_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.in_valid (pix_in.valid),
		.in_ready (pix_in.ready),
		.pix      (pix),
		.out_valid(v1),
		.out_ready(r1),
		.out_data (front_d)
	);

	ycc2bgr_mult u_mult (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (v1),
		.in_ready (r1),
		.in_data  (front_d),
		.out_valid(v2),
		.out_ready(r2),
		.out_data (prod_d)
	);

	ycc2bgr_sum u_sum (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (v2),
		.in_ready (r2),
		.in_data  (prod_d),
		.out_valid(v3),
		.out_ready(r3),
		.out_data (sum_d)
	);

	ycc2bgr_clamp u_clamp (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (v3),
		.in_ready (r3),
		.in_data  (sum_d),
		.out_valid(pix_out.valid),
		.out_ready(pix_out.ready),
		.out_data (bgr_d)
	);

	assign pix_out.blue  = bgr_d.blue;
	assign pix_out.green = bgr_d.green;
	assign pix_out.red   = bgr_d.red;

endmodule

/* dv/ycbcr_to_bgr_pixel_converter_test.sv */
module ycbcr_to_bgr_pixel_converter_test;

	localparam int HALF_PERIOD = 6;
	localparam int RESET_CYCLES = 11;
	localparam int DRAIN_TAIL = 8;
	localparam int MAX_IDLE = 12;
	localparam int RANDOM_PIXELS = 500;
	localparam int CYCLE_LIMIT = 200000;
	localparam logic [ycc2bgr_pkg::IDX_W-1:0] REG_UNUSED = 2'd3;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [ycc2bgr_pkg::IDX_W-1:0] cfg_index;
	logic [ycc2bgr_pkg::CFG_W-1:0] cfg_data;

	ycc2bgr_in_if pix_in();
	ycc2bgr_out_if pix_out();

	ycbcr_to_bgr_pixel_converter dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.pix_in(pix_in),
		.pix_out(pix_out)
	);

	// shadow of the converter's registers
	ycc2bgr_pkg::fmt_t fmt_cfg;
	logic matrix_cfg;
	logic limited_cfg;

	ycc2bgr_pkg::bgr_t bgr_expected[$];
	int fail_count;
	int pixels_sent;
	int results_checked;
	int settings_seen;
	int cycle_count;
	bit source_quiet;
	bit sink_quiet;

	initial begin
		clk = 1'b0;
	end

	always begin
		#HALF_PERIOD clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$error("timeout after %0d cycles, %0d results outstanding", cycle_count,
				bgr_expected.size());
			$display("status: fail");
			$finish;
		end
	end

	function automatic int idle_cycles(bit quiet);
		if (quiet)
			return 0;
		return $urandom_range(0, MAX_IDLE);
	endfunction

	// Q16 accumulator -> byte, round half up, clamp to 0..255
	function automatic logic [ycc2bgr_pkg::BYTE_W-1:0] round_clamp(longint acc);
		longint v;
		v = acc + 32768;
		if (v < 0)
			return 8'd0;
		v = v >>> 16;
		if (v > 255)
			return 8'd255;
		return v[ycc2bgr_pkg::BYTE_W-1:0];
	endfunction

	function automatic ycc2bgr_pkg::bgr_t predict_bgr(ycc2bgr_pkg::pix_t p);
		ycc2bgr_pkg::bgr_t r;
		logic [ycc2bgr_pkg::BYTE_W-1:0] u_byte;
		logic [ycc2bgr_pkg::BYTE_W-1:0] v_byte;
		longint lum;
		longint cu;
		longint cv;
		longint kb;
		longint kgu;
		longint kgv;
		longint kr;
		case (fmt_cfg)
			ycc2bgr_pkg::FMT_BGR24: begin
				r.blue = p.sample_first;
				r.green = p.sample_second;
				r.red = p.sample_third;
			end
			ycc2bgr_pkg::FMT_RGB24: begin
				r.blue = p.sample_third;
				r.green = p.sample_second;
				r.red = p.sample_first;
			end
			default: begin
				case ({matrix_cfg, limited_cfg})
					2'b00: begin kb = 116130; kgu = 22553; kgv = 46802; kr = 91881; end
					2'b01: begin kb = 132201; kgu = 25675; kgv = 53279; kr = 104597; end
					2'b10: begin kb = 121609; kgu = 12276; kgv = 30679; kr = 103206; end
					default: begin kb = 138438; kgu = 13975; kgv = 34925; kr = 117489; end
				endcase
				// NV21 interleaves V before U
				u_byte = (fmt_cfg == ycc2bgr_pkg::FMT_NV21) ? p.sample_third : p.sample_second;
				v_byte = (fmt_cfg == ycc2bgr_pkg::FMT_NV21) ? p.sample_second : p.sample_third;
				cu = longint'(u_byte) - 128;
				cv = longint'(v_byte) - 128;
				if (limited_cfg)
					lum = (longint'(p.sample_first) - 16) * 76309;
				else
					lum = longint'(p.sample_first) * 65536;
				r.blue = round_clamp(lum + kb * cu);
				r.green = round_clamp(lum - kgu * cu - kgv * cv);
				r.red = round_clamp(lum + kr * cv);
			end
		endcase
		return r;
	endfunction

	// called at a falling edge with the converter idle
	task automatic write_reg(logic [ycc2bgr_pkg::IDX_W-1:0] idx,
			logic [ycc2bgr_pkg::CFG_W-1:0] data);
		cfg_we = 1'b1;
		cfg_index = idx;
		cfg_data = data;
		@(negedge clk);
		cfg_we = 1'b0;
		case (idx)
			ycc2bgr_pkg::REG_IN_FMT: fmt_cfg = ycc2bgr_pkg::fmt_t'(data);
			ycc2bgr_pkg::REG_COLOR_MATRIX: matrix_cfg = data[0];
			ycc2bgr_pkg::REG_QUANTIZATION_RANGE: limited_cfg = data[0];
			default: ;
		endcase
	endtask

	task automatic wait_drained();
		while (bgr_expected.size() != 0)
			@(negedge clk);
		repeat (DRAIN_TAIL) @(negedge clk);
	endtask

	// enters and leaves at a falling edge; valid stays high on return, until a gap or end_burst drops it
	task automatic send_pixel(logic [ycc2bgr_pkg::BYTE_W-1:0] first,
			logic [ycc2bgr_pkg::BYTE_W-1:0] second, logic [ycc2bgr_pkg::BYTE_W-1:0] third);
		ycc2bgr_pkg::pix_t p;
		int gap;
		p.sample_first = first;
		p.sample_second = second;
		p.sample_third = third;
		gap = idle_cycles(source_quiet);
		if (gap > 0) begin
			pix_in.valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		pix_in.valid = 1'b1;
		pix_in.sample_first = first;
		pix_in.sample_second = second;
		pix_in.sample_third = third;
		do
			@(posedge clk);
		while (!pix_in.ready);
		bgr_expected.push_back(predict_bgr(p));
		pixels_sent++;
		@(negedge clk);
	endtask

	task automatic end_burst();
		pix_in.valid = 1'b0;
		wait_drained();
	endtask

	initial begin : result_sink
		int stall;
		ycc2bgr_pkg::bgr_t exp_bgr;
		pix_out.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			stall = idle_cycles(sink_quiet);
			if (stall > 0) begin
				pix_out.ready = 1'b0;
				repeat (stall) @(negedge clk);
			end
			pix_out.ready = 1'b1;
			do
				@(posedge clk);
			while (!pix_out.valid);
			if (bgr_expected.size() == 0) begin
				$error("result with no pixel pending: blue %0d green %0d red %0d",
					pix_out.blue, pix_out.green, pix_out.red);
				fail_count++;
			end else begin
				exp_bgr = bgr_expected.pop_front();
				results_checked++;
				if (pix_out.blue !== exp_bgr.blue) begin
					$error("blue: expected %0d, got %0d", exp_bgr.blue, pix_out.blue);
					fail_count++;
				end
				if (pix_out.green !== exp_bgr.green) begin
					$error("green: expected %0d, got %0d", exp_bgr.green, pix_out.green);
					fail_count++;
				end
				if (pix_out.red !== exp_bgr.red) begin
					$error("red: expected %0d, got %0d", exp_bgr.red, pix_out.red);
					fail_count++;
				end
			end
			@(negedge clk);
		end
	end

	task automatic test_reset_settings();
		// registers untouched: NV12, BT.601, full range
		send_pixel(8'd0, 8'd128, 8'd128);
		send_pixel(8'd255, 8'd0, 8'd255);
		send_pixel(8'd128, 8'd255, 8'd0);
		end_burst();
		settings_seen++;
	endtask

	task automatic test_nv21_bt709_limited();
		write_reg(ycc2bgr_pkg::REG_IN_FMT, ycc2bgr_pkg::FMT_NV21);
		write_reg(ycc2bgr_pkg::REG_COLOR_MATRIX, 2'd1);
		write_reg(ycc2bgr_pkg::REG_QUANTIZATION_RANGE, 2'd1);
		// luma below 16 goes negative before the clamp
		send_pixel(8'd0, 8'd0, 8'd0);
		send_pixel(8'd15, 8'd255, 8'd0);
		send_pixel(8'd16, 8'd128, 8'd128);
		send_pixel(8'd235, 8'd240, 8'd16);
		send_pixel(8'd255, 8'd255, 8'd255);
		send_pixel(8'd128, 8'd0, 8'd255);
		end_burst();
		settings_seen++;
	endtask

	task automatic test_nv12_matrix_range();
		write_reg(ycc2bgr_pkg::REG_IN_FMT, ycc2bgr_pkg::FMT_NV12);
		write_reg(ycc2bgr_pkg::REG_COLOR_MATRIX, 2'd1);
		write_reg(ycc2bgr_pkg::REG_QUANTIZATION_RANGE, 2'd0);
		send_pixel(8'd255, 8'd0, 8'd0);
		send_pixel(8'd0, 8'd255, 8'd255);
		send_pixel(8'd77, 8'd200, 8'd30);
		end_burst();
		write_reg(ycc2bgr_pkg::REG_COLOR_MATRIX, 2'd0);
		write_reg(ycc2bgr_pkg::REG_QUANTIZATION_RANGE, 2'd1);
		send_pixel(8'd10, 8'd240, 8'd16);
		send_pixel(8'd235, 8'd16, 8'd240);
		end_burst();
		settings_seen += 2;
	endtask

	task automatic test_rgb_reorder();
		// matrix and range must have no effect here
		write_reg(ycc2bgr_pkg::REG_COLOR_MATRIX, 2'd1);
		write_reg(ycc2bgr_pkg::REG_QUANTIZATION_RANGE, 2'd1);
		write_reg(ycc2bgr_pkg::REG_IN_FMT, ycc2bgr_pkg::FMT_RGB24);
		send_pixel(8'd1, 8'd2, 8'd3);
		send_pixel(8'd255, 8'd0, 8'd128);
		end_burst();
		write_reg(ycc2bgr_pkg::REG_IN_FMT, ycc2bgr_pkg::FMT_BGR24);
		send_pixel(8'd0, 8'd255, 8'd170);
		send_pixel(8'd255, 8'd128, 8'd0);
		end_burst();
		settings_seen += 2;
	endtask

	task automatic test_register_quirks();
		write_reg(ycc2bgr_pkg::REG_IN_FMT, ycc2bgr_pkg::FMT_NV12);
		// unknown index is dropped; wide data keeps only bit 0
		write_reg(REG_UNUSED, 2'd3);
		write_reg(ycc2bgr_pkg::REG_COLOR_MATRIX, 2'd2);
		write_reg(ycc2bgr_pkg::REG_QUANTIZATION_RANGE, 2'd3);
		send_pixel(8'd200, 8'd60, 8'd190);
		send_pixel(8'd5, 8'd128, 8'd255);
		send_pixel(8'd240, 8'd255, 8'd0);
		end_burst();
		settings_seen++;
	endtask

	function automatic logic [ycc2bgr_pkg::BYTE_W-1:0] pick_byte();
		logic [ycc2bgr_pkg::BYTE_W-1:0] corner[6] = '{8'd0, 8'd255, 8'd16, 8'd235, 8'd240,
			8'd128};
		if ($urandom_range(0, 7) == 0)
			return corner[$urandom_range(0, 5)];
		return ycc2bgr_pkg::BYTE_W'($urandom());
	endfunction

	task automatic test_random_traffic();
		int sent;
		int burst;
		sent = 0;
		while (sent < RANDOM_PIXELS) begin
			// idle here: nothing outstanding
			write_reg(ycc2bgr_pkg::REG_IN_FMT, ycc2bgr_pkg::CFG_W'($urandom()));
			write_reg(ycc2bgr_pkg::REG_COLOR_MATRIX, ycc2bgr_pkg::CFG_W'($urandom()));
			write_reg(ycc2bgr_pkg::REG_QUANTIZATION_RANGE, ycc2bgr_pkg::CFG_W'($urandom()));
			if ($urandom_range(0, 5) == 0)
				write_reg(REG_UNUSED, ycc2bgr_pkg::CFG_W'($urandom()));
			settings_seen++;
			source_quiet = ($urandom_range(0, 3) == 0);
			sink_quiet = ($urandom_range(0, 3) == 0);
			burst = $urandom_range(15, 70);
			repeat (burst) begin
				if ($urandom_range(0, 39) == 0) begin
					pix_in.valid = 1'b0;
					wait_drained();
				end
				send_pixel(pick_byte(), pick_byte(), pick_byte());
				sent++;
			end
			end_burst();
		end
		source_quiet = 1'b0;
		sink_quiet = 1'b0;
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		pix_in.valid = 1'b0;
		pix_in.sample_first = '0;
		pix_in.sample_second = '0;
		pix_in.sample_third = '0;
		fmt_cfg = ycc2bgr_pkg::FMT_NV12;
		matrix_cfg = 1'b0;
		limited_cfg = 1'b0;
		fail_count = 0;
		pixels_sent = 0;
		results_checked = 0;
		settings_seen = 0;
		cycle_count = 0;
		source_quiet = 1'b0;
		sink_quiet = 1'b0;
		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_reset_settings();
		test_nv21_bt709_limited();
		test_nv12_matrix_range();
		test_rgb_reorder();
		test_register_quirks();
		test_random_traffic();

		end_burst();
		$display("converted %0d pixels, checked %0d results", pixels_sent, results_checked);
		$display("covered %0d register settings over all formats, matrices and ranges",
			settings_seen);
		if (fail_count == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
